// ===== sv/ils_pkg.sv =====
package ils_pkg;

    // Storage geometry of the list.
    localparam int DEPTH  = 16;
    localparam int ELEM_W = 32;

    // Widths that follow from the geometry.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed widths of the transaction fields.
    localparam int REQ_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    // Width used when a position is compared with the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_GET    = 3'd4,
        REQ_SET    = 3'd5
    } req_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Operations the datapath carries out.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_PUSH,
        DP_POP,
        DP_INSERT,
        DP_REMOVE,
        DP_GET,
        DP_SET
    } dp_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic    exec;
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } dp_stat_t;

endpackage

// ===== sv/ils_ctrl.sv =====
module ils_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ils_pkg::REQ_W-1:0] req_type,
    input  logic [ils_pkg::POS_W-1:0] position,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  ils_pkg::dp_stat_t       stat,
    output ils_pkg::dp_cmd_t        cmd
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic [ils_pkg::CMP_W-1:0] pos_cmp;
    logic [ils_pkg::CMP_W-1:0] cnt_cmp;

    // A new transaction is taken when no result waits or the waiting one leaves now.
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);

    assign pos_cmp = ils_pkg::CMP_W'(position);
    assign cnt_cmp = ils_pkg::CMP_W'(stat.count);

    // Decode the request and check it against the current fill level.
    always_comb
    begin
        cmd.exec   = accept;
        cmd.op     = ils_pkg::DP_NONE;
        cmd.status = ils_pkg::ST_OK;
        unique case (req_type)
            ils_pkg::REQ_PUSH:
            begin
                if (stat.full)
                    cmd.status = ils_pkg::ST_FULL;
                else
                    cmd.op = ils_pkg::DP_PUSH;
            end
            ils_pkg::REQ_POP:
            begin
                if (stat.empty)
                    cmd.status = ils_pkg::ST_EMPTY;
                else
                    cmd.op = ils_pkg::DP_POP;
            end
            ils_pkg::REQ_INSERT:
            begin
                if (stat.full)
                    cmd.status = ils_pkg::ST_FULL;
                else if (pos_cmp > cnt_cmp)
                    cmd.status = ils_pkg::ST_RANGE;
                else
                    cmd.op = ils_pkg::DP_INSERT;
            end
            ils_pkg::REQ_REMOVE:
            begin
                if (stat.empty)
                    cmd.status = ils_pkg::ST_EMPTY;
                else if (pos_cmp >= cnt_cmp)
                    cmd.status = ils_pkg::ST_RANGE;
                else
                    cmd.op = ils_pkg::DP_REMOVE;
            end
            ils_pkg::REQ_GET:
            begin
                if (pos_cmp >= cnt_cmp)
                    cmd.status = ils_pkg::ST_RANGE;
                else
                    cmd.op = ils_pkg::DP_GET;
            end
            ils_pkg::REQ_SET:
            begin
                if (pos_cmp >= cnt_cmp)
                    cmd.status = ils_pkg::ST_RANGE;
                else
                    cmd.op = ils_pkg::DP_SET;
            end
            default:
            begin
                cmd.op = ils_pkg::DP_NONE;
            end
        endcase
    end

    // Result handshake state.
    always_comb
    begin
        state_next = state_reg;
        if (accept)
            state_next = S_HOLD;
        else if (out_ready)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/ils_datapath.sv =====
module ils_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ils_pkg::dp_cmd_t            cmd,
    output ils_pkg::dp_stat_t           stat,
    input  logic [ils_pkg::POS_W-1:0]   position,
    input  logic [ils_pkg::VALUE_W-1:0] item_value,
    output logic [ils_pkg::VALUE_W-1:0] read_value,
    output logic [ils_pkg::POS_W-1:0]   placed_at,
    output logic [ils_pkg::POS_W-1:0]   entry_count,
    output logic [ils_pkg::STAT_W-1:0]  status
);

    logic [ils_pkg::ELEM_W-1:0]  cell_reg  [ils_pkg::DEPTH];
    logic [ils_pkg::ELEM_W-1:0]  cell_next [ils_pkg::DEPTH];
    logic [ils_pkg::CNT_W-1:0]   count_reg;
    logic [ils_pkg::CNT_W-1:0]   count_next;
    logic [ils_pkg::VALUE_W-1:0] read_value_reg;
    logic [ils_pkg::VALUE_W-1:0] read_value_next;
    logic [ils_pkg::POS_W-1:0]   placed_at_reg;
    logic [ils_pkg::POS_W-1:0]   placed_at_next;
    logic [ils_pkg::STAT_W-1:0]  status_reg;
    logic [ils_pkg::ELEM_W-1:0]  wr_value;
    logic [ils_pkg::CNT_W-1:0]   count_m1;
    logic [ils_pkg::IDX_W-1:0]   rd_addr;
    logic [ils_pkg::CMP_W-1:0]   pos_cmp;
    logic [ils_pkg::CMP_W-1:0]   cnt_cmp;

    assign wr_value = ils_pkg::ELEM_W'(item_value);
    assign count_m1 = count_reg - 1'b1;
    assign pos_cmp  = ils_pkg::CMP_W'(position);
    assign cnt_cmp  = ils_pkg::CMP_W'(count_reg);

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == ils_pkg::CNT_W'(ils_pkg::DEPTH));
    assign stat.empty = (count_reg == '0);

    // Each cell picks its neighbor below, its neighbor above, the new value or itself.
    for (genvar g = 0; g < ils_pkg::DEPTH; g++)
    begin : g_cell
        localparam logic [ils_pkg::CMP_W-1:0] GI = ils_pkg::CMP_W'(g);

        logic [ils_pkg::ELEM_W-1:0] from_below;
        logic [ils_pkg::ELEM_W-1:0] from_above;

        if (g > 0)
        begin : g_below
            assign from_below = cell_reg[g-1];
        end
        else
        begin : g_no_below
            assign from_below = cell_reg[g];
        end

        if (g < ils_pkg::DEPTH - 1)
        begin : g_above
            assign from_above = cell_reg[g+1];
        end
        else
        begin : g_no_above
            assign from_above = cell_reg[g];
        end

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            unique case (cmd.op)
                ils_pkg::DP_PUSH:
                begin
                    if (GI == cnt_cmp)
                        cell_next[g] = wr_value;
                end
                ils_pkg::DP_INSERT:
                begin
                    if (GI == pos_cmp)
                        cell_next[g] = wr_value;
                    else if ((GI > pos_cmp) && (GI <= cnt_cmp))
                        cell_next[g] = from_below;
                end
                ils_pkg::DP_REMOVE:
                begin
                    if (GI >= pos_cmp)
                        cell_next[g] = from_above;
                end
                ils_pkg::DP_SET:
                begin
                    if (GI == pos_cmp)
                        cell_next[g] = wr_value;
                end
                ils_pkg::DP_NONE,
                ils_pkg::DP_POP,
                ils_pkg::DP_GET:
                begin
                    cell_next[g] = cell_reg[g];
                end
                default:
                begin
                    cell_next[g] = cell_reg[g];
                end
            endcase
        end
    end

    // Single read port: the last entry for pop, the addressed one for get.
    assign rd_addr = (cmd.op == ils_pkg::DP_POP) ? count_m1[ils_pkg::IDX_W-1:0]
                                                 : position[ils_pkg::IDX_W-1:0];

    // Result fields and the new count.
    always_comb
    begin
        read_value_next = '0;
        placed_at_next  = '0;
        count_next      = count_reg;
        unique case (cmd.op)
            ils_pkg::DP_PUSH:
            begin
                placed_at_next = ils_pkg::POS_W'(count_reg);
                count_next     = count_reg + 1'b1;
            end
            ils_pkg::DP_INSERT:
            begin
                count_next = count_reg + 1'b1;
            end
            ils_pkg::DP_POP:
            begin
                read_value_next = ils_pkg::VALUE_W'(cell_reg[rd_addr]);
                count_next      = count_m1;
            end
            ils_pkg::DP_REMOVE:
            begin
                count_next = count_m1;
            end
            ils_pkg::DP_GET:
            begin
                read_value_next = ils_pkg::VALUE_W'(cell_reg[rd_addr]);
            end
            ils_pkg::DP_NONE,
            ils_pkg::DP_SET:
            begin
                count_next = count_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Entry storage holds no reset value.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < ils_pkg::DEPTH; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    // Result register, loaded once per accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            read_value_reg <= read_value_next;
            placed_at_reg  <= placed_at_next;
            status_reg     <= cmd.status;
        end
    end

    assign read_value  = read_value_reg;
    assign placed_at   = placed_at_reg;
    assign entry_count = ils_pkg::POS_W'(count_reg);
    assign status      = status_reg;

endmodule

// ===== sv/indexed_list_store_core.sv =====
// A result is valid in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while results are taken at once; the entry
// cells shift the whole list in parallel, and the single result register sets the pace.
// Reset (rst_n, asynchronous, active low) empties the list and drops any pending result;
// entry cells keep no reset value and are never read before they are written.
module indexed_list_store_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ils_pkg::REQ_W-1:0]   req_type,
    input  logic [ils_pkg::POS_W-1:0]   position,
    input  logic [ils_pkg::VALUE_W-1:0] item_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ils_pkg::VALUE_W-1:0] read_value,
    output logic [ils_pkg::POS_W-1:0]   placed_at,
    output logic [ils_pkg::POS_W-1:0]   entry_count,
    output logic [ils_pkg::STAT_W-1:0]  status
);

    ils_pkg::dp_cmd_t  cmd;
    ils_pkg::dp_stat_t stat;

    // Handshake control and request checking.
    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Entry cells, count and result register.
    ils_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .position    (position),
        .item_value  (item_value),
        .read_value  (read_value),
        .placed_at   (placed_at),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Request codes that the block does not use; they must leave the list alone.
    localparam logic [ils_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [ils_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // Length of the forced receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 64;

    typedef struct {
        logic [ils_pkg::REQ_W-1:0]   req;
        logic [ils_pkg::POS_W-1:0]   pos;
        logic [ils_pkg::VALUE_W-1:0] val;
    } list_request_t;

    typedef struct {
        logic [ils_pkg::VALUE_W-1:0] read_value;
        logic [ils_pkg::POS_W-1:0]   placed_at;
        logic [ils_pkg::POS_W-1:0]   entry_count;
        logic [ils_pkg::STAT_W-1:0]  status;
    } list_result_t;

    // Shape of a stretch of random traffic.
    typedef enum {TREND_GROW, TREND_SHRINK, TREND_STEADY} trend_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ils_pkg::REQ_W-1:0]     req_type = '0;
    logic [ils_pkg::POS_W-1:0]     position = '0;
    logic [ils_pkg::VALUE_W-1:0]   item_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ils_pkg::VALUE_W-1:0]   read_value;
    logic [ils_pkg::POS_W-1:0]     placed_at;
    logic [ils_pkg::POS_W-1:0]     entry_count;
    logic [ils_pkg::STAT_W-1:0]    status;

    // Traffic shaping; the percentages change only between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_go = 1'b0;
    logic        rx_hold = 1'b0;

    // Requests waiting to be driven, and the list length they will leave behind.
    list_request_t pending_requests[$];
    int unsigned   planned_len = 0;
    int unsigned   requests_queued = 0;
    int unsigned   requests_taken = 0;

    // Predicted contents of the list and the results still owed by the block.
    logic [ils_pkg::ELEM_W-1:0] list_mem [ils_pkg::DEPTH];
    int unsigned                list_len = 0;
    list_result_t               expected_results[$];

    int unsigned error_count = 0;

    indexed_list_store_core u_top (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous overall limit on the run.
    initial
    begin
        #5_000_000;
        $display("** indexed_list_store_core: FAILED **");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < 40)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%08h, expected 0x%08h", name, got, want));
    endtask

    // Queue one request and track the list length it will produce, so that
    // later positions can be aimed at the live part of the list.
    task automatic queue_request(input logic [ils_pkg::REQ_W-1:0] req,
                                 input logic [ils_pkg::POS_W-1:0] pos,
                                 input logic [ils_pkg::VALUE_W-1:0] val);
        list_request_t rq;
        rq.req = req;
        rq.pos = pos;
        rq.val = val;
        pending_requests.push_back(rq);
        requests_queued++;
        unique case (req)
            ils_pkg::REQ_PUSH:
                if (planned_len < ils_pkg::DEPTH) planned_len++;
            ils_pkg::REQ_POP:
                if (planned_len > 0) planned_len--;
            ils_pkg::REQ_INSERT:
                if (planned_len < ils_pkg::DEPTH && pos <= planned_len) planned_len++;
            ils_pkg::REQ_REMOVE:
                if (planned_len > 0 && pos < planned_len) planned_len--;
            default:    ;
        endcase
    endtask

    // Apply one request to the predicted list and work out the result it owes.
    task automatic apply_list_request(input list_request_t rq, output list_result_t res);
        int unsigned pos;
        int unsigned i;
        logic [ils_pkg::ELEM_W-1:0] val;
        pos = rq.pos;
        val = rq.val[ils_pkg::ELEM_W-1:0];
        res.read_value = '0;
        res.placed_at = '0;
        res.status = ils_pkg::ST_OK;
        unique case (rq.req)
            ils_pkg::REQ_PUSH:
            begin
                if (list_len >= ils_pkg::DEPTH)
                    res.status = ils_pkg::ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    res.placed_at = ils_pkg::POS_W'(list_len);
                    list_len++;
                end
            end
            ils_pkg::REQ_POP:
            begin
                if (list_len == 0)
                    res.status = ils_pkg::ST_EMPTY;
                else
                begin
                    list_len--;
                    res.read_value = ils_pkg::VALUE_W'(list_mem[list_len]);
                end
            end
            ils_pkg::REQ_INSERT:
            begin
                // A full list is reported ahead of a bad position.
                if (list_len >= ils_pkg::DEPTH)
                    res.status = ils_pkg::ST_FULL;
                else if (pos > list_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            ils_pkg::REQ_REMOVE:
            begin
                if (list_len == 0)
                    res.status = ils_pkg::ST_EMPTY;
                else if (pos >= list_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ils_pkg::REQ_GET:
            begin
                if (pos >= list_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                    res.read_value = ils_pkg::VALUE_W'(list_mem[pos]);
            end
            ils_pkg::REQ_SET:
            begin
                if (pos >= list_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                    list_mem[pos] = val;
            end
            default: ;
        endcase
        res.entry_count = ils_pkg::POS_W'(list_len);
    endtask

    // Random traffic in stretches that grow, shrink or hold the list, so that
    // the full and empty corners are visited again and again.
    task automatic random_run(input int unsigned n);
        int unsigned               done;
        int unsigned               chunk;
        int unsigned               roll;
        int                        i;
        int unsigned               cut [6];
        logic [ils_pkg::REQ_W-1:0] op_order [6];
        logic [ils_pkg::REQ_W-1:0] req;
        logic [ils_pkg::POS_W-1:0] pos;
        trend_t                    trend;
        op_order[0] = ils_pkg::REQ_PUSH;
        op_order[1] = ils_pkg::REQ_INSERT;
        op_order[2] = ils_pkg::REQ_POP;
        op_order[3] = ils_pkg::REQ_REMOVE;
        op_order[4] = ils_pkg::REQ_GET;
        op_order[5] = ils_pkg::REQ_SET;
        done = 0;
        while (done < n)
        begin
            trend = trend_t'($urandom_range(2));
            unique case (trend)
                TREND_GROW:   cut = '{30, 60, 68, 76, 88, 97};
                TREND_SHRINK: cut = '{8, 16, 46, 76, 88, 97};
                default:      cut = '{16, 32, 48, 64, 80, 97};
            endcase
            chunk = $urandom_range(40, 8);
            while (chunk > 0 && done < n)
            begin
                // Pick the operation; the top few percent are the unused codes.
                roll = $urandom_range(99);
                req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
                for (i = 5; i >= 0; i--)
                    if (roll < cut[i])
                        req = op_order[i];
                // Mostly a position inside the list, sometimes its end or anywhere.
                roll = $urandom_range(99);
                if (roll < 80)
                begin
                    if (req == ils_pkg::REQ_INSERT)
                        pos = ils_pkg::POS_W'($urandom_range(planned_len));
                    else if (planned_len == 0)
                        pos = '0;
                    else
                        pos = ils_pkg::POS_W'($urandom_range(planned_len - 1));
                end
                else if (roll < 90)
                    pos = ils_pkg::POS_W'(planned_len);
                else
                    pos = ils_pkg::POS_W'($urandom_range(31));
                queue_request(req, pos, $urandom());
                chunk--;
                done++;
            end
        end
    endtask

    // Wait until every queued request is taken and every result has come back.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (requests_taken != requests_queued || expected_results.size() != 0);
    endtask

    // Request driver: offers the next pending transaction when the slot is free, with random idle gaps.
    always @(posedge clk)
    begin : request_driver
        list_request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_requests.pop_front();
                in_valid <= 1'b1;
                req_type <= nxt.req;
                position <= nxt.pos;
                item_value <= nxt.val;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus the forced hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, so the block fills up and pushes back on its input.
    initial
    begin : receiver_hold
        int n;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge clk)
    begin : result_monitor
        list_request_t rq;
        list_result_t  got;
        list_result_t  want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                rq.req = req_type;
                rq.pos = position;
                rq.val = item_value;
                apply_list_request(rq, want);
                expected_results.push_back(want);
                requests_taken++;
            end
            if (out_valid && out_ready)
            begin
                got.read_value = read_value;
                got.placed_at = placed_at;
                got.entry_count = entry_count;
                got.status = status;
                if (expected_results.size() == 0)
                    report_error("result transaction with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_value", 32'(got.read_value), 32'(want.read_value));
                    check_field("placed_at", 32'(got.placed_at), 32'(want.placed_at));
                    check_field("entry_count", 32'(got.entry_count),
                                32'(want.entry_count));
                    check_field("status", 32'(got.status), 32'(want.status));
                end
            end
        end
    end

    // Test sequence.
    initial
    begin : stimulus
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: refusals on an empty list, unused codes, then inserts at the
        // front, the end and the middle, reads and writes, and removal again.
        queue_request(ils_pkg::REQ_POP, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_REMOVE, 5'd5, 32'h0);
        queue_request(ils_pkg::REQ_GET, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_SET, 5'd0, 32'hDEADBEEF);
        queue_request(ils_pkg::REQ_INSERT, 5'd1, 32'h11111111);
        queue_request(REQ_SPARE_LO, 5'd31, 32'hFFFFFFFF);
        queue_request(REQ_SPARE_HI, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_PUSH, 5'd31, 32'hFFFFFFFF);
        queue_request(ils_pkg::REQ_PUSH, 5'd0, 32'h00000000);
        queue_request(ils_pkg::REQ_INSERT, 5'd0, 32'hA5A5A5A5);
        queue_request(ils_pkg::REQ_INSERT, 5'd3, 32'h5A5A5A5A);
        queue_request(ils_pkg::REQ_INSERT, 5'd2, 32'h12345678);
        queue_request(ils_pkg::REQ_GET, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_GET, 5'd4, 32'h0);
        queue_request(ils_pkg::REQ_GET, 5'd5, 32'h0);
        queue_request(ils_pkg::REQ_GET, 5'd31, 32'h0);
        queue_request(ils_pkg::REQ_SET, 5'd4, 32'h80000001);
        queue_request(ils_pkg::REQ_REMOVE, 5'd1, 32'h0);
        queue_request(ils_pkg::REQ_REMOVE, 5'd4, 32'h0);
        queue_request(ils_pkg::REQ_REMOVE, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_GET, 5'd2, 32'h0);
        while (planned_len > 0)
            queue_request(ils_pkg::REQ_POP, 5'd0, 32'h0);

        // Raise the receiver hold-off, fill to capacity, hit the full and range
        // refusals at the top, then empty the list and hit the empty refusals.
        hold_go = 1'b1;
        while (planned_len < ils_pkg::DEPTH)
            queue_request(ils_pkg::REQ_PUSH, ils_pkg::POS_W'($urandom_range(31)), $urandom());
        queue_request(ils_pkg::REQ_PUSH, 5'd0, $urandom());
        queue_request(ils_pkg::REQ_INSERT, 5'd31, $urandom());
        queue_request(ils_pkg::REQ_INSERT, 5'd0, $urandom());
        queue_request(ils_pkg::REQ_GET, ils_pkg::POS_W'(ils_pkg::DEPTH - 1), 32'h0);
        queue_request(ils_pkg::REQ_SET, ils_pkg::POS_W'(ils_pkg::DEPTH), $urandom());
        queue_request(ils_pkg::REQ_REMOVE, ils_pkg::POS_W'(ils_pkg::DEPTH), 32'h0);
        while (planned_len > 0)
            queue_request(ils_pkg::REQ_POP, ils_pkg::POS_W'($urandom_range(31)), 32'h0);
        queue_request(ils_pkg::REQ_POP, 5'd0, 32'h0);
        queue_request(ils_pkg::REQ_REMOVE, 5'd31, 32'h0);

        // Random traffic under each flow-control pattern.
        random_run(200);
        wait_for_drain();

        send_idle_pct = 81;
        recv_stall_pct = 0;
        random_run(200);
        wait_for_drain();

        send_idle_pct = 0;
        recv_stall_pct = 81;
        random_run(200);
        wait_for_drain();

        send_idle_pct = 37;
        recv_stall_pct = 37;
        random_run(200);
        wait_for_drain();

        // Let any stray result show up before closing.
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_error("results still outstanding at end of run");
        if (error_count == 0)
            $display("** indexed_list_store_core: PASSED **");
        else
            $display("** indexed_list_store_core: FAILED **");
        $finish;
    end

endmodule
